@@ sv/vsl_pkg.sv @@
// ---------------------------------------------------------------------------
// vsl_pkg: shared types and constants of the velocity slew limiter
// Fixed field widths, register indexes, item codes and the payload structs.
// ---------------------------------------------------------------------------
package vsl_pkg;

  // field widths
  localparam int VEL_WIDTH     = 24;
  localparam int LIM_WIDTH     = 23;
  localparam int TIMEOUT_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = LIM_WIDTH;

  // compare and sum width: holds a velocity, a negated limit and cur + step
  localparam int CALC_WIDTH = ((VEL_WIDTH > LIM_WIDTH) ? VEL_WIDTH : LIM_WIDTH) + 1;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_LIN   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_ANG   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LIN_DELTA = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ANG_DELTA = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TIMEOUT   = 3'd4;

  // register reset values
  localparam logic [LIM_WIDTH-1:0]     MAX_LIN_RST   = 23'd13107;
  localparam logic [LIM_WIDTH-1:0]     MAX_ANG_RST   = 23'd52429;
  localparam logic [LIM_WIDTH-1:0]     LIN_DELTA_RST = 23'd164;
  localparam logic [LIM_WIDTH-1:0]     ANG_DELTA_RST = 23'd655;
  localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RST   = 16'd10;

  // item codes
  localparam logic CMD_TARGET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic                        cmd;
    logic signed [VEL_WIDTH-1:0] target_lin;
    logic signed [VEL_WIDTH-1:0] target_ang;
  } vsl_in_t;

  typedef struct packed {
    logic signed [VEL_WIDTH-1:0] out_lin;
    logic signed [VEL_WIDTH-1:0] out_ang;
  } vsl_out_t;

  typedef struct packed {
    logic [LIM_WIDTH-1:0]     max_lin;
    logic [LIM_WIDTH-1:0]     max_ang;
    logic [LIM_WIDTH-1:0]     lin_delta;
    logic [LIM_WIDTH-1:0]     ang_delta;
    logic [TIMEOUT_WIDTH-1:0] timeout_ticks;
  } vsl_cfg_t;

  // smoother state except the idle tick counter, whose width is a parameter
  typedef struct packed {
    logic signed [VEL_WIDTH-1:0] goal_lin;
    logic signed [VEL_WIDTH-1:0] goal_ang;
    logic signed [VEL_WIDTH-1:0] now_lin;
    logic signed [VEL_WIDTH-1:0] now_ang;
    logic                        cmd_seen;
  } vsl_state_t;

endpackage

@@ sv/vsl_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// vsl_cfg_regs: configuration register file
// Limits, per-tick steps and timeout, written through a plain write port.
// ---------------------------------------------------------------------------
module vsl_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [vsl_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [vsl_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  output vsl_pkg::vsl_cfg_t                    cfg
);

  vsl_pkg::vsl_cfg_t cfg_r;
  vsl_pkg::vsl_cfg_t cfg_nxt;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        vsl_pkg::REG_MAX_LIN:   cfg_nxt.max_lin   = cfg_data;
        vsl_pkg::REG_MAX_ANG:   cfg_nxt.max_ang   = cfg_data;
        vsl_pkg::REG_LIN_DELTA: cfg_nxt.lin_delta = cfg_data;
        vsl_pkg::REG_ANG_DELTA: cfg_nxt.ang_delta = cfg_data;
        vsl_pkg::REG_TIMEOUT:
          cfg_nxt.timeout_ticks = cfg_data[vsl_pkg::TIMEOUT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_lin       <= vsl_pkg::MAX_LIN_RST;
      cfg_r.max_ang       <= vsl_pkg::MAX_ANG_RST;
      cfg_r.lin_delta     <= vsl_pkg::LIN_DELTA_RST;
      cfg_r.ang_delta     <= vsl_pkg::ANG_DELTA_RST;
      cfg_r.timeout_ticks <= vsl_pkg::TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/vsl_step.sv @@
// ---------------------------------------------------------------------------
// vsl_step: single-pass update of the smoother for one item
// Clamp and store on a target item; timeout and slew on a tick item.
// ---------------------------------------------------------------------------
module vsl_step #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  vsl_pkg::vsl_in_t              item,
  input  vsl_pkg::vsl_cfg_t             cfg,
  input  vsl_pkg::vsl_state_t           st,
  input  logic [TICK_COUNT_WIDTH-1:0]   idle_ticks,
  output vsl_pkg::vsl_state_t           st_nxt,
  output logic [TICK_COUNT_WIDTH-1:0]   idle_ticks_nxt,
  output vsl_pkg::vsl_out_t             result
);

  localparam int VW = vsl_pkg::VEL_WIDTH;
  localparam int LW = vsl_pkg::LIM_WIDTH;
  localparam int CW = vsl_pkg::CALC_WIDTH;
  localparam int TOW = vsl_pkg::TIMEOUT_WIDTH;
  localparam int CMPW = (TICK_COUNT_WIDTH > TOW) ? TICK_COUNT_WIDTH : TOW;

  function automatic logic signed [CW-1:0] sext_vel(input logic signed [VW-1:0] v);
    sext_vel = signed'({{(CW-VW){v[VW-1]}}, v});
  endfunction

  function automatic logic signed [CW-1:0] zext_lim(input logic [LW-1:0] v);
    zext_lim = signed'({{(CW-LW){1'b0}}, v});
  endfunction

  // clamp to plus or minus the limit
  function automatic logic signed [VW-1:0] clamp_mag(input logic signed [VW-1:0] v,
                                                     input logic [LW-1:0] lim);
    logic signed [CW-1:0] ve;
    logic signed [CW-1:0] le;
    logic signed [CW-1:0] r;
    ve = sext_vel(v);
    le = zext_lim(lim);
    if (ve > le)       r = le;
    else if (ve < -le) r = -le;
    else               r = ve;
    clamp_mag = r[VW-1:0];
  endfunction

  // move toward the goal by at most one step, never past it
  function automatic logic signed [VW-1:0] slew(input logic signed [VW-1:0] cur,
                                                input logic signed [VW-1:0] goal,
                                                input logic [LW-1:0] step);
    logic signed [CW-1:0] ce;
    logic signed [CW-1:0] ge;
    logic signed [CW-1:0] se;
    logic signed [CW-1:0] up;
    logic signed [CW-1:0] dn;
    logic signed [CW-1:0] r;
    ce = sext_vel(cur);
    ge = sext_vel(goal);
    se = zext_lim(step);
    up = ce + se;
    dn = ce - se;
    if (ge > ce)      r = (up < ge) ? up : ge;
    else if (ge < ce) r = (dn > ge) ? dn : ge;
    else              r = ce;
    slew = r[VW-1:0];
  endfunction

  logic [TICK_COUNT_WIDTH-1:0] idle_inc;
  logic [CMPW-1:0]             idle_cmp;
  logic [CMPW-1:0]             timeout_cmp;
  logic                        timed_out;
  logic signed [VW-1:0]        goal_lin_tick;
  logic signed [VW-1:0]        goal_ang_tick;

  // saturating idle counter and timeout check
  assign idle_inc    = (&idle_ticks) ? idle_ticks : idle_ticks + TICK_COUNT_WIDTH'(1);
  assign idle_cmp    = CMPW'(idle_inc);
  assign timeout_cmp = CMPW'(cfg.timeout_ticks);
  assign timed_out   = st.cmd_seen && (idle_cmp > timeout_cmp);

  assign goal_lin_tick = timed_out ? '0 : st.goal_lin;
  assign goal_ang_tick = timed_out ? '0 : st.goal_ang;

  // next state per item kind
  always_comb begin
    st_nxt         = st;
    idle_ticks_nxt = idle_ticks;
    if (item.cmd == vsl_pkg::CMD_TARGET) begin
      st_nxt.goal_lin = clamp_mag(item.target_lin, cfg.max_lin);
      st_nxt.goal_ang = clamp_mag(item.target_ang, cfg.max_ang);
      st_nxt.cmd_seen = 1'b1;
      idle_ticks_nxt  = '0;
    end else begin
      st_nxt.goal_lin = goal_lin_tick;
      st_nxt.goal_ang = goal_ang_tick;
      st_nxt.now_lin  = slew(st.now_lin, goal_lin_tick, cfg.lin_delta);
      st_nxt.now_ang  = slew(st.now_ang, goal_ang_tick, cfg.ang_delta);
      idle_ticks_nxt  = idle_inc;
    end
  end

  assign result.out_lin = st_nxt.now_lin;
  assign result.out_ang = st_nxt.now_ang;

endmodule

@@ sv/velocity_slew_limiter_top.sv @@
// ---------------------------------------------------------------------------
// velocity_slew_limiter_top: two-axis velocity smoother, Q7.16
// Target items set clamped goals; tick items slew the velocities and report.
// ---------------------------------------------------------------------------
//   channel  handshake             payload
//   in       in_valid / in_ready   in_item (cmd, target_lin, target_ang)
//   out      out_valid / out_ready out_item (out_lin, out_ang)
//   cfg      cfg_we                cfg_index, cfg_data
//
// one item per cycle unless a tick item is held back: input register, one pass of
// clamp / compare / add logic that updates the state, then the result register; a
// tick item's result is written to the result register when the item leaves the
// input register and is held there until taken, a target item gives no result.
// reset (synchronous, rst_n low) clears the state and loads register defaults.
// a result waiting in the output register holds a tick item in the input
// register and the input with it; target items still pass.
// ---------------------------------------------------------------------------
module velocity_slew_limiter_top #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vsl_pkg::vsl_in_t                    in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vsl_pkg::vsl_out_t                   out_item,
  input  logic                                cfg_we,
  input  logic [vsl_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [vsl_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  vsl_pkg::vsl_cfg_t           cfg;
  logic                        s1_valid_r;
  vsl_pkg::vsl_in_t            s1_item_r;
  logic                        s1_fire;
  vsl_pkg::vsl_state_t         st_r;
  vsl_pkg::vsl_state_t         st_nxt;
  logic [TICK_COUNT_WIDTH-1:0] idle_r;
  logic [TICK_COUNT_WIDTH-1:0] idle_nxt;
  vsl_pkg::vsl_out_t           result;
  logic                        out_valid_r;
  vsl_pkg::vsl_out_t           out_item_r;

  vsl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vsl_step #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_step (
    .item           (s1_item_r),
    .cfg            (cfg),
    .st             (st_r),
    .idle_ticks     (idle_r),
    .st_nxt         (st_nxt),
    .idle_ticks_nxt (idle_nxt),
    .result         (result)
  );

  // stage one moves on unless a tick would overwrite an untaken result
  assign s1_fire  = s1_valid_r &&
                    ((s1_item_r.cmd == vsl_pkg::CMD_TARGET) || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // smoother state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      idle_r <= '0;
    end else if (s1_fire) begin
      st_r   <= st_nxt;
      idle_r <= idle_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && (s1_item_r.cmd == vsl_pkg::CMD_TICK)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_item_r.cmd == vsl_pkg::CMD_TICK)) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
